// File: design/byte_stuffing_framer_assert.svh
// Assertion macros shared by the framer modules.
`ifndef BYTE_STUFFING_FRAMER_ASSERT_SVH
`define BYTE_STUFFING_FRAMER_ASSERT_SVH

// A property that must hold in the same cycle, checked outside reset.
`define BSF_ASSERT_NOW(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("byte stuffing framer: check failed");

// A consequence that must hold in the cycle after its cause.
`define BSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("byte stuffing framer: check failed");

`endif

// File: design/bsf_pkg.sv
package bsf_pkg;

  localparam logic [7:0] FrameFlag  = 8'h7E;
  localparam logic [7:0] CtrlEscape = 8'h7D;
  localparam logic [7:0] EscapeXor  = 8'h20;

  localparam int unsigned FifoDepthDefault = 2;

  // One classified input beat: data is already transformed when esc is set.
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       first;
    logic       last;
  } bsf_desc_t;

endpackage

// File: design/byte_stuffing_framer.sv
// Channel   Direction  Handshake                 Beat payload
// input     in         in_valid_i / in_stall_o   data_byte_i, frame_first_i, frame_last_i
// output    out        out_valid_o / out_stall_i out_byte_o, run_end_o
//
// An input beat gives 1-4 output beats; the emitter sends one byte per cycle unless stalled.
// Input beats are taken every cycle while the descriptor queue has room (FifoDepth entries).
// With the emitter idle, an accepted beat is first written into the descriptor queue, and its
// first byte is then registered into the output register from the queue head.
// Reset clears the queue pointers, the pending run and the output valid; there is no clearing pass.
// A stalled output holds the emitter; the queue keeps taking input beats until it fills.
`include "byte_stuffing_framer_assert.svh"

module byte_stuffing_framer
  import bsf_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_first_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  bsf_desc_t in_desc, head_desc;
  logic      fifo_full, fifo_empty, fifo_pop, fifo_push;

  assign in_stall_o = fifo_full;
  assign fifo_push  = in_valid_i && !fifo_full;

  bsf_front u_front (
    .data_byte_i   (data_byte_i),
    .frame_first_i (frame_first_i),
    .frame_last_i  (frame_last_i),
    .desc_o        (in_desc)
  );

  bsf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (in_desc),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .rdata_o (head_desc),
    .empty_o (fifo_empty)
  );

  bsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_desc),
    .empty_i     (fifo_empty),
    .pop_o       (fifo_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o)
  );

endmodule

// File: design/bsf_front.sv
module bsf_front
  import bsf_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  logic       frame_first_i,
  input  logic       frame_last_i,
  output bsf_desc_t  desc_o
);

  logic needs_esc;

  assign needs_esc = (data_byte_i == FrameFlag) || (data_byte_i == CtrlEscape);

  always_comb begin
    desc_o.esc   = needs_esc;
    desc_o.data  = needs_esc ? (data_byte_i ^ EscapeXor) : data_byte_i;
    desc_o.first = frame_first_i;
    desc_o.last  = frame_last_i;
  end

endmodule

// File: design/bsf_fifo.sv
`include "byte_stuffing_framer_assert.svh"

module bsf_fifo
  import bsf_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bsf_desc_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output bsf_desc_t rdata_o,
  output logic      empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  bsf_desc_t         mem_q [Depth];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `BSF_ASSERT_NOW(a_count_bound, clk_i, rst_ni, count_q <= CW'(Depth))
  `BSF_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, !pop_i || !empty_o)
  `BSF_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i,
                   count_q == $past(count_q) + 1'b1)

endmodule

// File: design/bsf_back.sv
`include "byte_stuffing_framer_assert.svh"

module bsf_back
  import bsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bsf_desc_t  head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o
);

  typedef struct packed {
    logic open;
    logic esc;
    logic data;
    logic close;
  } bsf_pend_t;

  bsf_pend_t  pend_q, pend_d;
  bsf_pend_t  src_pend, rem_pend;
  logic [7:0] cur_data_q, cur_data_d;
  logic [7:0] src_data, next_byte;
  logic       cur_active, have_work, advance;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_end_q, run_end_d;

  assign cur_active = |pend_q;
  assign have_work  = cur_active || !empty_i;
  assign advance    = have_work && (!out_valid_q || !out_stall_i);
  assign pop_o      = advance && !cur_active;

  always_comb begin
    if (cur_active) begin
      src_pend = pend_q;
      src_data = cur_data_q;
    end else begin
      src_pend = '{open: head_i.first, esc: head_i.esc, data: 1'b1, close: head_i.last};
      src_data = head_i.data;
    end
    rem_pend = src_pend;
    if (src_pend.open) begin
      next_byte     = FrameFlag;
      rem_pend.open = 1'b0;
    end else if (src_pend.esc) begin
      next_byte    = CtrlEscape;
      rem_pend.esc = 1'b0;
    end else if (src_pend.data) begin
      next_byte     = src_data;
      rem_pend.data = 1'b0;
    end else begin
      next_byte      = FrameFlag;
      rem_pend.close = 1'b0;
    end
  end

  always_comb begin
    pend_d      = pend_q;
    cur_data_d  = cur_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    if (advance) begin
      pend_d      = rem_pend;
      cur_data_d  = src_data;
      out_valid_d = 1'b1;
      out_byte_d  = next_byte;
      run_end_d   = (rem_pend == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_data_q <= cur_data_d;
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;

  `BSF_ASSERT_NOW(a_rest_behind_open_run, clk_i, rst_ni,
                  !cur_active || (out_valid_q && !run_end_q))
  `BSF_ASSERT_NEXT(a_run_continues, clk_i, rst_ni,
                   out_valid_q && !out_stall_i && !run_end_q, out_valid_q)
  `BSF_ASSERT_NOW(a_pop_when_idle, clk_i, rst_ni, !pop_o || !cur_active)

endmodule
